>>> hdl/prs_pkg.sv
// Shared constants for the priority round-robin task scheduler.
`timescale 1ns / 1ps
package prs_pkg;

	localparam int NUM_TASKS_DEF      = 16;
	localparam int NUM_PRIORITIES_DEF = 32;

	localparam int TASK_W  = 4;
	localparam int PRIO_W  = 5;
	localparam int LEN_W   = 5;
	localparam int SLICE_W = 8;
	localparam int CMD_W   = 3;
	localparam int STAT_W  = 3;

	localparam logic [SLICE_W-1:0] DEFAULT_SLICE_RST = 8'd10;

	// commands
	localparam logic [CMD_W-1:0] CMD_CREATE = 3'd0;
	localparam logic [CMD_W-1:0] CMD_REMOVE = 3'd1;
	localparam logic [CMD_W-1:0] CMD_YIELD  = 3'd2;
	localparam logic [CMD_W-1:0] CMD_TICK   = 3'd3;
	localparam logic [CMD_W-1:0] CMD_COMMIT = 3'd4;

	// status codes
	localparam logic [STAT_W-1:0] ST_OK       = 3'd0;
	localparam logic [STAT_W-1:0] ST_NOCHANGE = 3'd1;
	localparam logic [STAT_W-1:0] ST_SWITCH   = 3'd2;
	localparam logic [STAT_W-1:0] ST_EMPTY    = 3'd3;
	localparam logic [STAT_W-1:0] ST_BADPRIO  = 3'd4;
	localparam logic [STAT_W-1:0] ST_QUEUED   = 3'd5;
	localparam logic [STAT_W-1:0] ST_INVALID  = 3'd6;

	// per-task run state
	localparam logic [1:0] RS_BLOCKED = 2'd0;
	localparam logic [1:0] RS_READY   = 2'd1;
	localparam logic [1:0] RS_RUNNING = 2'd2;

endpackage

>>> hdl/prs_first_set.sv
// Finds the highest priority (lowest index) level with a non-empty ready list.
`timescale 1ns / 1ps
module prs_first_set
	import prs_pkg::*;
#(
	parameter int NUM_PRIORITIES = NUM_PRIORITIES_DEF,
	localparam int PW = (NUM_PRIORITIES > 1) ? $clog2(NUM_PRIORITIES) : 1
) (
	input  logic [NUM_PRIORITIES-1:0] mask,
	output logic [PW-1:0]             idx,
	output logic                      found
);

	always_comb begin
		idx   = '0;
		found = 1'b0;
		for (int i = NUM_PRIORITIES - 1; i >= 0; i--) begin
			if (mask[i]) begin
				idx   = PW'(i);
				found = 1'b1;
			end
		end
	end

endmodule

>>> hdl/priority_round_robin_task_scheduler_core.sv
// Top level: bitmap priority scheduler with round-robin time slices.
//
//  channel | signals                                         | dir | meaning
//  --------+-------------------------------------------------+-----+---------------------
//  in      | in_valid in_ready command task_id priority_req  | in  | one command beat
//          | slice_length                                    |     |
//  out     | out_valid out_ready status next_task next_valid | out | one result beat
//          | running_task current_valid                      |     | per command
//  cfg     | cfg_valid cfg_ready cfg_data                    | in  | default_slice write
//
//  A command beat taken into the input register is decided when it leaves it, where the result
//  register and the scheduler state load together; the result is offered from the result
//  register, and a new beat can be taken every cycle while the result is not stalled.
//  The whole command (schedule, rotate, reschedule) is one pass of logic between
//  the input register and the state/result registers.
//  Reset clears all lists, the ready mask and the current/next selection.
//  A stalled result freezes the state and backs up into the input register.
`timescale 1ns / 1ps
module priority_round_robin_task_scheduler_core
	import prs_pkg::*;
#(
	parameter int NUM_PRIORITIES = NUM_PRIORITIES_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [CMD_W-1:0]    command,
	input  logic [TASK_W-1:0]   task_id,
	input  logic [5:0]          priority_req,
	input  logic [SLICE_W-1:0]  slice_length,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [STAT_W-1:0]   status,
	output logic [TASK_W-1:0]   next_task,
	output logic                next_valid,
	output logic [TASK_W-1:0]   running_task,
	output logic                current_valid,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [SLICE_W-1:0]  cfg_data
);

	localparam int NT = NUM_TASKS_DEF;
	localparam int NP = NUM_PRIORITIES;
	localparam int PW = (NP > 1) ? $clog2(NP) : 1;

	// ---------------- input register and flow control ----------------
	logic               valid_s1;
	logic [CMD_W-1:0]   cmd_s1;
	logic [TASK_W-1:0]  tid_s1;
	logic [5:0]         prio_s1;
	logic [SLICE_W-1:0] slice_s1;
	logic               out_valid_q;
	logic [STAT_W-1:0]  status_q;
	logic               advance, go;

	assign advance  = !out_valid_q || out_ready;
	assign in_ready = !valid_s1 || advance;
	assign go       = valid_s1 && advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			cmd_s1   <= command;
			tid_s1   <= task_id;
			prio_s1  <= priority_req;
			slice_s1 <= slice_length;
		end
	end

	// ---------------- configuration ----------------
	logic [SLICE_W-1:0] default_slice_q;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			default_slice_q <= DEFAULT_SLICE_RST;
		end else if (cfg_valid) begin
			default_slice_q <= cfg_data;
		end
	end

	// ---------------- scheduler state ----------------
	logic [NT-1:0]      created_q, queued_q;
	logic [1:0]         run_state_q [NT];
	logic [PRIO_W-1:0]  slot_prio_q [NT];
	logic [SLICE_W-1:0] slice_left_q [NT];
	logic [SLICE_W-1:0] slice_reload_q [NT];
	logic [TASK_W-1:0]  fwd_q [NT];
	logic [TASK_W-1:0]  bwd_q [NT];
	logic [TASK_W-1:0]  first_q [NP];
	logic [TASK_W-1:0]  last_q [NP];
	logic [LEN_W-1:0]   len_q [NP];
	logic [NP-1:0]      mask_q;
	logic [TASK_W-1:0]  running_q, chosen_q;
	logic               running_present_q, chosen_present_q;

	// ---------------- command decode (single pass) ----------------
	logic [TASK_W-1:0]  t, r;
	logic [PW-1:0]      pi, tp, rp, pmin;
	logic               found, r_ok, rot, prio_ok;
	logic [NP-1:0]      mask_add, mask_eval;
	logic [TASK_W-1:0]  first_pmin, sched_slot;
	logic [SLICE_W-1:0] slice_eff, dec;
	logic               is_current;

	// next-state requests
	logic [STAT_W-1:0]  st_d;
	logic [TASK_W-1:0]  chosen_d, running_d;
	logic               chosen_present_d, running_present_d;
	logic [NP-1:0]      mask_d;
	logic               fwd_we, bwd_we, first_we, last_we, len_we, sl_we, setup_we;
	logic [TASK_W-1:0]  fwd_wa, fwd_wd, bwd_wa, bwd_wd, first_wd, last_wd, sl_wa;
	logic [PW-1:0]      first_wa, last_wa, len_wa;
	logic [LEN_W-1:0]   len_wd;
	logic [SLICE_W-1:0] sl_wd;
	logic               q_set, q_clr;
	logic               rs_a_we, rs_b_we;
	logic [TASK_W-1:0]  rs_a_wa, rs_b_wa;
	logic [1:0]         rs_a_wd, rs_b_wd;

	assign t       = tid_s1;
	assign r       = running_q;
	assign pi      = PW'(prio_s1);
	assign tp      = PW'(slot_prio_q[t]);
	assign rp      = PW'(slot_prio_q[r]);
	assign prio_ok = prio_s1 < 6'(NP);
	assign r_ok    = running_present_q && created_q[r] && queued_q[r]
		&& (run_state_q[r] == RS_RUNNING);
	assign slice_eff  = (slice_s1 == '0) ? default_slice_q : slice_s1;
	assign dec        = (slice_left_q[r] != '0) ? slice_left_q[r] - 8'd1 : '0;
	assign is_current = running_present_q && (running_q == t);

	always_comb begin
		mask_add     = '0;
		mask_add[pi] = 1'b1;
		mask_eval    = (cmd_s1 == CMD_CREATE) ? (mask_q | mask_add) : mask_q;
	end

	prs_first_set #(.NUM_PRIORITIES(NP)) u_first_set (
		.mask  (mask_eval),
		.idx   (pmin),
		.found (found)
	);

	assign first_pmin = first_q[pmin];

	// head after an optional rotation of the running task's list
	assign sched_slot = (rot && (pmin == rp)) ? fwd_q[r] : first_pmin;

	always_comb begin
		st_d              = ST_INVALID;
		chosen_d          = chosen_q;
		chosen_present_d  = chosen_present_q;
		running_d         = running_q;
		running_present_d = running_present_q;
		mask_d            = mask_q;
		rot      = 1'b0;
		fwd_we   = 1'b0; fwd_wa   = r;  fwd_wd   = r;
		bwd_we   = 1'b0; bwd_wa   = r;  bwd_wd   = last_q[rp];
		first_we = 1'b0; first_wa = rp; first_wd = fwd_q[r];
		last_we  = 1'b0; last_wa  = rp; last_wd  = r;
		len_we   = 1'b0; len_wa   = pi; len_wd   = '0;
		sl_we    = 1'b0; sl_wa    = r;  sl_wd    = slice_reload_q[r];
		setup_we = 1'b0;
		q_set    = 1'b0;
		q_clr    = 1'b0;
		rs_a_we  = 1'b0; rs_a_wa = r; rs_a_wd = RS_READY;
		rs_b_we  = 1'b0; rs_b_wa = t; rs_b_wd = RS_RUNNING;

		unique case (cmd_s1)
			CMD_CREATE: begin
				if (queued_q[t]) begin
					st_d = ST_QUEUED;
				end else if (!prio_ok) begin
					st_d = ST_BADPRIO;
				end else begin
					setup_we = 1'b1;
					q_set    = 1'b1;
					rs_b_we  = 1'b1;
					rs_b_wd  = RS_READY;
					if (len_q[pi] == '0) begin
						first_we = 1'b1;
						first_wa = pi;
						first_wd = t;
					end else begin
						fwd_we = 1'b1;
						fwd_wa = last_q[pi];
						fwd_wd = t;
						bwd_we = 1'b1;
						bwd_wa = t;
						bwd_wd = last_q[pi];
					end
					last_we = 1'b1;
					last_wa = pi;
					last_wd = t;
					len_we  = 1'b1;
					len_wa  = pi;
					len_wd  = len_q[pi] + 5'd1;
					mask_d  = mask_eval;
					chosen_present_d = 1'b1;
					chosen_d = ((pmin == pi) && (len_q[pi] == '0)) ? t : first_pmin;
					if (running_present_q && (chosen_d != r))
						st_d = ST_SWITCH;
					else
						st_d = ST_OK;
				end
			end
			CMD_REMOVE: begin
				if (queued_q[t]) begin
					st_d    = ST_OK;
					q_clr   = 1'b1;
					rs_b_we = 1'b1;
					rs_b_wd = RS_BLOCKED;
					len_we  = 1'b1;
					len_wa  = tp;
					if (len_q[tp] <= 5'd1) begin
						len_wd     = '0;
						mask_d[tp] = 1'b0;
					end else begin
						len_wd = len_q[tp] - 5'd1;
						if (first_q[tp] == t) begin
							first_we = 1'b1;
							first_wa = tp;
							first_wd = fwd_q[t];
						end else begin
							fwd_we = 1'b1;
							fwd_wa = bwd_q[t];
							fwd_wd = fwd_q[t];
						end
						if (last_q[tp] == t) begin
							last_we = 1'b1;
							last_wa = tp;
							last_wd = bwd_q[t];
						end else begin
							bwd_we = 1'b1;
							bwd_wa = fwd_q[t];
							bwd_wd = bwd_q[t];
						end
					end
				end
			end
			CMD_YIELD: begin
				if (r_ok) begin
					sl_we = 1'b1;
					rot   = (len_q[rp] > 5'd1) && (first_q[rp] == r);
					if (!found) begin
						st_d             = ST_EMPTY;
						chosen_present_d = 1'b0;
						chosen_d         = '0;
					end else begin
						chosen_present_d = 1'b1;
						chosen_d         = sched_slot;
						st_d = (sched_slot != r) ? ST_SWITCH : ST_NOCHANGE;
					end
				end
			end
			CMD_TICK: begin
				if (!running_present_q) begin
					st_d = ST_NOCHANGE;
				end else if (r_ok) begin
					if (!found) begin
						st_d             = ST_EMPTY;
						chosen_present_d = 1'b0;
						chosen_d         = '0;
					end else begin
						chosen_present_d = 1'b1;
						chosen_d         = first_pmin;
						if (first_pmin != r) begin
							st_d = ST_SWITCH;
						end else if (len_q[rp] <= 5'd1) begin
							sl_we = 1'b1;
							st_d  = ST_NOCHANGE;
						end else if (dec != '0) begin
							sl_we = 1'b1;
							sl_wd = dec;
							st_d  = ST_NOCHANGE;
						end else begin
							// slice used up: reload and rotate to the tail
							sl_we    = 1'b1;
							rot      = (first_q[rp] == r);
							chosen_d = sched_slot;
							st_d = (sched_slot != r) ? ST_SWITCH : ST_NOCHANGE;
						end
					end
				end
			end
			CMD_COMMIT: begin
				if (created_q[t] && chosen_present_q && (chosen_q == t) && queued_q[t]
					&& (is_current || (run_state_q[t] == RS_READY))) begin
					st_d              = ST_OK;
					rs_a_we           = running_present_q && !is_current
						&& (run_state_q[r] == RS_RUNNING);
					rs_b_we           = 1'b1;
					running_d         = t;
					running_present_d = 1'b1;
				end
			end
			default: begin
				st_d = ST_INVALID;
			end
		endcase

		if (rot) begin
			first_we = 1'b1;
			fwd_we   = 1'b1;
			fwd_wa   = last_q[rp];
			bwd_we   = 1'b1;
			last_we  = 1'b1;
		end
	end

	// ---------------- state update ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			created_q         <= '0;
			queued_q          <= '0;
			mask_q            <= '0;
			running_q         <= '0;
			running_present_q <= 1'b0;
			chosen_q          <= '0;
			chosen_present_q  <= 1'b0;
			out_valid_q       <= 1'b0;
			status_q          <= ST_OK;
			for (int i = 0; i < NT; i++) run_state_q[i] <= RS_BLOCKED;
			for (int i = 0; i < NP; i++) len_q[i] <= '0;
		end else begin
			if (advance) out_valid_q <= valid_s1;
			if (go) begin
				status_q          <= st_d;
				mask_q            <= mask_d;
				running_q         <= running_d;
				running_present_q <= running_present_d;
				chosen_q          <= chosen_d;
				chosen_present_q  <= chosen_present_d;
				if (setup_we) created_q[t] <= 1'b1;
				if (q_set)    queued_q[t]  <= 1'b1;
				if (q_clr)    queued_q[t]  <= 1'b0;
				if (rs_a_we)  run_state_q[rs_a_wa] <= rs_a_wd;
				if (rs_b_we)  run_state_q[rs_b_wa] <= rs_b_wd;
				if (len_we)   len_q[len_wa] <= len_wd;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			if (setup_we) begin
				slot_prio_q[t]    <= PRIO_W'(prio_s1);
				slice_left_q[t]   <= slice_eff;
				slice_reload_q[t] <= slice_eff;
			end
			if (sl_we)    slice_left_q[sl_wa] <= sl_wd;
			if (fwd_we)   fwd_q[fwd_wa]       <= fwd_wd;
			if (bwd_we)   bwd_q[bwd_wa]       <= bwd_wd;
			if (first_we) first_q[first_wa]   <= first_wd;
			if (last_we)  last_q[last_wa]     <= last_wd;
		end
	end

	// ---------------- result ports ----------------
	// state only moves together with the result register, so it can feed the port
	assign out_valid     = out_valid_q;
	assign status        = status_q;
	assign next_task     = chosen_q;
	assign next_valid    = chosen_present_q;
	assign running_task  = running_q;
	assign current_valid = running_present_q;

	// ---------------- checks ----------------
	logic [NP-1:0] nonempty;
	logic [NT-1:0] running_vec;

	always_comb begin
		for (int i = 0; i < NP; i++) nonempty[i] = (len_q[i] != '0);
		for (int i = 0; i < NT; i++) running_vec[i] = (run_state_q[i] == RS_RUNNING);
	end

	a_mask_matches_lists: assert property (@(posedge clk) disable iff (!arst_n)
		mask_q == nonempty)
		else $error("ready mask out of step with list lengths");

	a_one_running: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(running_vec) <= 1)
		else $error("more than one task in running state");

	a_queued_created: assert property (@(posedge clk) disable iff (!arst_n)
		(queued_q & ~created_q) == '0)
		else $error("queued slot never created");

	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (valid_s1 && out_valid_q && !out_ready))
		else $error("input stalled without a blocked result");

endmodule
